// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every property is clocked on the rising edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/utf8v_pkg.sv =====
package utf8v_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_KEEP    = 64;
  localparam int DEF_OFFSET_BITS = 16;

  // Width of the keep_chars register and its value after reset.
  localparam int             KEEP_W     = 7;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

  // Width of the offset and count fields of a result.
  localparam int OUT_W = 16;

  // Number of finished strings that can wait between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_e;

  // Where the kept tail offset of a result comes from.
  typedef enum logic [1:0] {
    KM_BYTES = 2'd0,  // nothing kept: total byte length
    KM_ZERO  = 2'd1,  // string no longer than the kept tail
    KM_RING  = 2'd2   // start offset read from the ring
  } keep_mode_e;

  // Summary of one finished string as it travels from front to back.
  typedef struct packed {
    status_e           status;
    keep_mode_e        mode;
    logic [OUT_W-1:0]  char_total;
    logic [OUT_W-1:0]  byte_total;
    logic [OUT_W-1:0]  ring_start;
  } job_t;

endpackage

// ===== sv/utf8v_front.sv =====
`include "assert_macros.svh"

module utf8v_front #(
  parameter int MAX_KEEP    = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [utf8v_pkg::KEEP_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            has_byte_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            end_of_text_i,
  output logic                            job_valid_o,
  input  logic                            job_ready_i,
  output utf8v_pkg::job_t                 job_o
);
  import utf8v_pkg::*;

  localparam int IW   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int KW   = $clog2(MAX_KEEP + 1);
  localparam int KCW  = (KW > KEEP_W) ? KW : KEEP_W;
  localparam int CMPW = (OFFSET_BITS > KW) ? OFFSET_BITS : KW;
  localparam int SW   = IW + 1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT = '1;
  localparam logic [IW-1:0]          LAST_SLOT    = IW'(MAX_KEEP - 1);

  // Byte classes and the bounds of strict UTF-8.
  localparam logic [7:0] ASCII_TOP = 8'h80;
  localparam logic [7:0] MASK_2B   = 8'he0;
  localparam logic [7:0] LEAD_2B   = 8'hc0;
  localparam logic [7:0] MASK_3B   = 8'hf0;
  localparam logic [7:0] LEAD_3B   = 8'he0;
  localparam logic [7:0] MASK_4B   = 8'hf8;
  localparam logic [7:0] LEAD_4B   = 8'hf0;
  localparam logic [7:0] MIN_2B    = 8'hc2;
  localparam logic [7:0] MAX_4B    = 8'hf4;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] LEAD_E0   = 8'he0;
  localparam logic [7:0] LEAD_ED   = 8'hed;
  localparam logic [7:0] LEAD_F0   = 8'hf0;
  localparam logic [7:0] LEAD_F4   = 8'hf4;
  localparam logic [7:0] SEC_A0    = 8'ha0;
  localparam logic [7:0] SEC_90    = 8'h90;

  logic [KEEP_W-1:0]      keep_q, keep_d;
  logic [1:0]             pend_q, pend_d;
  logic [7:0]             lead_q, lead_d;
  logic                   second_q, second_d;
  logic                   bad_q, bad_d;
  logic                   long_q, long_d;
  logic [OFFSET_BITS-1:0] offs_q, offs_d;
  logic [OFFSET_BITS-1:0] count_q, count_d;
  logic [IW-1:0]          ptr_q, ptr_d;
  logic                   job_valid_q, job_valid_d;
  job_t                   job_q, job_d;
  logic [OFFSET_BITS-1:0] rd_q;

  logic [OFFSET_BITS-1:0] ring_mem [MAX_KEEP];

  logic                   accept;
  logic                   take;
  logic                   last;
  logic                   ring_we;
  logic [KW-1:0]          keep_eff;
  logic [KCW-1:0]         keep_ext;
  logic [SW-1:0]          rd_diff;
  logic [IW-1:0]          rd_addr;
  status_e                status_n;
  keep_mode_e             mode_n;

  assign in_ready_o = !job_valid_q || job_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = accept && has_byte_i;
  assign last       = accept && end_of_text_i;

  // Tail length clamped to the ring depth.
  assign keep_ext = KCW'(keep_q);
  assign keep_eff = (keep_ext > KCW'(MAX_KEEP)) ? KW'(MAX_KEEP) : KW'(keep_ext);

  // Decoder: at most one byte per transfer, plus the string summary on the final transfer.
  always_comb begin
    keep_d      = keep_q;
    pend_d      = pend_q;
    lead_d      = lead_q;
    second_d    = second_q;
    bad_d       = bad_q;
    long_d      = long_q;
    offs_d      = offs_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    job_valid_d = job_valid_q;
    job_d       = job_q;
    ring_we     = 1'b0;

    if (cfg_valid_i) begin
      keep_d = cfg_data_i;
    end

    if (take) begin
      if (offs_q == OFFSET_LIMIT) begin
        long_d = 1'b1;
      end else begin
        if (!bad_q) begin
          if (pend_q == 2'd0) begin
            // A new character starts here.
            ring_we = 1'b1;
            ptr_d   = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
            count_d = count_q + 1'b1;
            if (data_byte_i < ASCII_TOP) begin
              pend_d = 2'd0;
            end else if ((data_byte_i & MASK_2B) == LEAD_2B) begin
              if (data_byte_i < MIN_2B) begin
                bad_d = 1'b1;
              end else begin
                pend_d   = 2'd1;
                lead_d   = data_byte_i;
                second_d = 1'b1;
              end
            end else if ((data_byte_i & MASK_3B) == LEAD_3B) begin
              pend_d   = 2'd2;
              lead_d   = data_byte_i;
              second_d = 1'b1;
            end else if ((data_byte_i & MASK_4B) == LEAD_4B) begin
              if (data_byte_i > MAX_4B) begin
                bad_d = 1'b1;
              end else begin
                pend_d   = 2'd3;
                lead_d   = data_byte_i;
                second_d = 1'b1;
              end
            end else begin
              bad_d = 1'b1;
            end
          end else begin
            // Continuation byte; the second byte also rules out overlong
            // forms, surrogates and code points above the Unicode range.
            if ((data_byte_i & CONT_MASK) != CONT_TAG) begin
              bad_d = 1'b1;
            end else if (second_q && ((lead_q == LEAD_E0 && data_byte_i < SEC_A0) ||
                                      (lead_q == LEAD_ED && data_byte_i >= SEC_A0) ||
                                      (lead_q == LEAD_F0 && data_byte_i < SEC_90) ||
                                      (lead_q == LEAD_F4 && data_byte_i >= SEC_90))) begin
              bad_d = 1'b1;
            end else begin
              second_d = 1'b0;
              pend_d   = pend_q - 1'b1;
            end
          end
        end
        offs_d = offs_q + 1'b1;
      end
    end

    // Status and tail source of the string as it stands after this byte.
    if (long_d) begin
      status_n = ST_TOO_LONG;
    end else if (bad_d || (pend_d != 2'd0)) begin
      status_n = ST_MALFORMED;
    end else begin
      status_n = ST_OK;
    end
    if (keep_eff == '0) begin
      mode_n = KM_BYTES;
    end else if (CMPW'(count_d) <= CMPW'(keep_eff)) begin
      mode_n = KM_ZERO;
    end else begin
      mode_n = KM_RING;
    end

    // Ring slot of the first kept character: (ptr - keep) modulo the depth.
    rd_diff = SW'(ptr_d) + SW'(MAX_KEEP) - SW'(keep_eff);
    if (rd_diff >= SW'(MAX_KEEP)) begin
      rd_diff = rd_diff - SW'(MAX_KEEP);
    end
    rd_addr = IW'(rd_diff);

    if (job_ready_i) begin
      job_valid_d = 1'b0;
    end
    if (last) begin
      job_valid_d      = 1'b1;
      job_d.status     = status_n;
      job_d.mode       = mode_n;
      job_d.char_total = OUT_W'(count_d);
      job_d.byte_total = OUT_W'(offs_d);
      job_d.ring_start = '0;
      // The next string starts from a clean state.
      pend_d   = 2'd0;
      lead_d   = '0;
      second_d = 1'b0;
      bad_d    = 1'b0;
      long_d   = 1'b0;
      offs_d   = '0;
      count_d  = '0;
      ptr_d    = '0;
    end
  end

  // Control and decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q      <= KEEP_RESET;
      pend_q      <= 2'd0;
      lead_q      <= '0;
      second_q    <= 1'b0;
      bad_q       <= 1'b0;
      long_q      <= 1'b0;
      offs_q      <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      keep_q      <= keep_d;
      pend_q      <= pend_d;
      lead_q      <= lead_d;
      second_q    <= second_d;
      bad_q       <= bad_d;
      long_q      <= long_d;
      offs_q      <= offs_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      job_valid_q <= job_valid_d;
    end
  end

  // Summary payload of the finished string.
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  // Ring of character start offsets, with the read taken on the final transfer.
  // A read of the slot written in the same cycle takes the new offset.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ptr_q] <= offs_q;
    end
    if (last) begin
      rd_q <= (ring_we && (ptr_q == rd_addr)) ? offs_q : ring_mem[rd_addr];
    end
  end

  always_comb begin
    job_o            = job_q;
    job_o.ring_start = OUT_W'(rd_q);
  end

  assign job_valid_o = job_valid_q;

  // An open second-byte check always has continuation bytes still due.
  `ASSERT_PROP(a_second_pending, clk_i, rst_ni, second_q |-> (pend_q != 2'd0),
               "second byte expected with no byte pending")
  // After a malformed byte no further character is opened in the string.
  `ASSERT_PROP(a_bad_freezes_ring, clk_i, rst_ni, bad_q && !last |=> $stable(ptr_q),
               "ring pointer moved after a malformed byte")

endmodule

// ===== sv/utf8v_queue.sv =====
`include "assert_macros.svh"

module utf8v_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  utf8v_pkg::job_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output utf8v_pkg::job_t pop_data_o
);
  import utf8v_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_ENTRY = PW'(QUEUE_DEPTH - 1);

  job_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push;
  logic          pop;

  assign push_ready_o = (count_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_ENTRY) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_ENTRY) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count never passes the depth.
  `ASSERT_PROP(a_count_range, clk_i, rst_ni, 1'b1 |-> (count_q <= CW'(QUEUE_DEPTH)),
               "queue fill count beyond its depth")

endmodule

// ===== sv/utf8v_back.sv =====
`include "assert_macros.svh"

module utf8v_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  utf8v_pkg::job_t             job_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output utf8v_pkg::status_e          status_o,
  output logic [utf8v_pkg::OUT_W-1:0] keep_from_o,
  output logic [utf8v_pkg::OUT_W-1:0] char_total_o
);
  import utf8v_pkg::*;

  logic             out_valid_q, out_valid_d;
  status_e          status_q;
  logic [OUT_W-1:0] keep_from_q, keep_from_d;
  logic [OUT_W-1:0] char_total_q, char_total_d;
  logic             load;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Result fields; a failed string reports zero offset and count.
  always_comb begin
    keep_from_d  = '0;
    char_total_d = '0;
    if (job_i.status == ST_OK) begin
      char_total_d = job_i.char_total;
      case (job_i.mode)
        KM_BYTES: keep_from_d = job_i.byte_total;
        KM_ZERO:  keep_from_d = '0;
        KM_RING:  keep_from_d = job_i.ring_start;
        default:  keep_from_d = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q     <= job_i.status;
      keep_from_q  <= keep_from_d;
      char_total_q <= char_total_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign keep_from_o  = keep_from_q;
  assign char_total_o = char_total_q;

  // A result that failed the check carries no offset and no count.
  `ASSERT_PROP(a_fail_zero, clk_i, rst_ni,
               out_valid_q && (status_q != ST_OK) |-> (keep_from_q == '0) && (char_total_q == '0),
               "failed result with nonzero fields")

endmodule

// ===== sv/utf8_validate_tail_chars.sv =====
// Input: one byte per cycle while s_axis_tready is high; decoder and ring are updated together.
// Path: summary register, then queue, then the output register that drives m_axis_tvalid.
// Results drain at one per cycle while m_axis_tready is high; a full queue with a summary
// waiting holds off input transfers.
// Reset: asynchronous, active low; keep_chars returns to 64, string state clears, no clearing pass.

module utf8_validate_tail_chars #(
  parameter int MAX_KEEP    = utf8v_pkg::DEF_MAX_KEEP,
  parameter int OFFSET_BITS = utf8v_pkg::DEF_OFFSET_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write: keep_chars.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [utf8v_pkg::KEEP_W-1:0] cfg_data_i,
  // Byte stream in.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]                   s_axis_tuser,   // [0] has_byte
  input  logic                         s_axis_tlast,   // end_of_text
  // Results out.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,   // [15:0] keep_from, [31:16] char_total
  output logic [1:0]                   m_axis_tuser    // [1:0] status
);
  import utf8v_pkg::*;

  job_t             front_job;
  logic             front_valid;
  logic             queue_ready;
  job_t             queue_job;
  logic             queue_valid;
  logic             back_ready;
  status_e          status;
  logic [OUT_W-1:0] keep_from;
  logic [OUT_W-1:0] char_total;

  assign cfg_ready_o = 1'b1;

  // Decoder, ring and string summary.
  utf8v_front #(
    .MAX_KEEP    (MAX_KEEP),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .has_byte_i    (s_axis_tuser[0]),
    .data_byte_i   (s_axis_tdata),
    .end_of_text_i (s_axis_tlast),
    .job_valid_o   (front_valid),
    .job_ready_i   (queue_ready),
    .job_o         (front_job)
  );

  // Finished strings waiting for the result stage.
  utf8v_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_job)
  );

  // Result forming and output register.
  utf8v_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (queue_valid),
    .in_ready_o   (back_ready),
    .job_i        (queue_job),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (status),
    .keep_from_o  (keep_from),
    .char_total_o (char_total)
  );

  assign m_axis_tdata = {char_total, keep_from};
  assign m_axis_tuser = status;

endmodule
